FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define GCKP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define GCKP_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define GCKP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GCKP_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: src/gckp_pkg.sv
// ----------------------------------------------------------------------------
// gckp_pkg
// Types and character codes shared by the control string parser.
// ----------------------------------------------------------------------------
package gckp_pkg;

  localparam logic [7:0] ChSemi   = 8'h3B;  // ';'
  localparam logic [7:0] ChComma  = 8'h2C;  // ','
  localparam logic [7:0] ChEquals = 8'h3D;  // '='
  localparam logic [7:0] ChPlus   = 8'h2B;  // '+'
  localparam logic [7:0] ChMinus  = 8'h2D;  // '-'
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChOne    = 8'h31;  // '1'
  localparam logic [7:0] ChNine   = 8'h39;  // '9'
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;  // first of tab, LF, VT, FF, CR
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [1:0] {
    KIND_PAIR    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,   // skipping leading whitespace
    PH_NUM  = 2'd1,   // in sign or digits
    PH_DONE = 2'd2    // number closed
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        minus;
    logic [31:0] acc;
    logic [7:0]  first;
    logic [1:0]  len;      // saturates at 2
  } value_t;

  typedef struct packed {
    logic        in_payload;
    logic [7:0]  key;
    logic        started;
    logic        equals;
    value_t      value;
  } parse_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  key_char;
    logic [31:0] magnitude;
    logic        is_negative;
    logic [7:0]  first_value_char;
    logic        value_empty;
    logic        value_is_one;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

FILE: src/gckp_value.sv
// ----------------------------------------------------------------------------
// gckp_value
// Folds one value byte into the running atoi-style decode.
// ----------------------------------------------------------------------------
module gckp_value (
  input  gckp_pkg::value_t  val_i,
  input  logic [7:0]        byte_i,
  output gckp_pkg::value_t  val_o
);

  logic        is_digit;
  logic        is_blank;
  logic        is_sign;
  logic [35:0] prod;

  assign is_digit = (byte_i >= gckp_pkg::ChZero) && (byte_i <= gckp_pkg::ChNine);
  assign is_blank = (byte_i == gckp_pkg::ChSpace) ||
                    ((byte_i >= gckp_pkg::ChTab) && (byte_i <= gckp_pkg::ChCr));
  assign is_sign  = (byte_i == gckp_pkg::ChPlus) || (byte_i == gckp_pkg::ChMinus);

  // acc * 10 + digit as two shifts and adds
  assign prod = {1'b0, val_i.acc, 3'b000} + {3'b000, val_i.acc, 1'b0}
              + {32'd0, byte_i[3:0] - gckp_pkg::ChZero[3:0]};

  always_comb begin
    val_o = val_i;
    if (val_i.len == 2'd0) begin
      val_o.first = byte_i;
    end
    if (val_i.len != 2'd2) begin
      val_o.len = val_i.len + 2'd1;
    end
    if (val_i.phase != gckp_pkg::PH_DONE) begin
      if (is_digit) begin
        // saturate at all ones
        val_o.acc   = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
        val_o.phase = gckp_pkg::PH_NUM;
      end else if ((val_i.phase == gckp_pkg::PH_SKIP) && is_blank) begin
        val_o.phase = gckp_pkg::PH_SKIP;
      end else if ((val_i.phase == gckp_pkg::PH_SKIP) && is_sign) begin
        val_o.minus = (byte_i == gckp_pkg::ChMinus);
        val_o.phase = gckp_pkg::PH_NUM;
      end else begin
        val_o.phase = gckp_pkg::PH_DONE;
      end
    end
  end

endmodule

FILE: src/gckp_step.sv
// ----------------------------------------------------------------------------
// gckp_step
// Next parse state and result for one byte of the control string.
// ----------------------------------------------------------------------------
module gckp_step (
  input  gckp_pkg::parse_t   st_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output gckp_pkg::parse_t   st_o,
  output logic               fire_o,
  output gckp_pkg::result_t  res_o
);

  gckp_pkg::value_t val_next;
  gckp_pkg::parse_t upd;
  logic             finish;
  logic             key_ok;
  logic             report;

  gckp_value u_value (
    .val_i  (st_i.value),
    .byte_i (byte_i),
    .val_o  (val_next)
  );

  always_comb begin
    case (upd.key)
      8'h61, 8'h66, 8'h74, 8'h69, 8'h70, 8'h73, 8'h76,
      8'h63, 8'h72, 8'h7A, 8'h6D, 8'h43, 8'h71, 8'h64: key_ok = 1'b1;
      default:                                         key_ok = 1'b0;
    endcase
  end

  // Advance the pair state for one byte and flag when the current pair finishes
  always_comb begin
    upd    = st_i;
    finish = 1'b0;
    if (st_i.in_payload) begin
      finish = 1'b0;
    end else if (byte_i == gckp_pkg::ChSemi) begin
      finish         = 1'b1;
      upd.in_payload = 1'b1;
    end else if (byte_i == gckp_pkg::ChComma) begin
      finish = 1'b1;
    end else begin
      if (!st_i.started) begin
        upd.key     = byte_i;
        upd.started = 1'b1;
      end else if (!st_i.equals) begin
        upd.equals = (byte_i == gckp_pkg::ChEquals);
      end else begin
        upd.value = val_next;
      end
      finish = last_i;
    end
  end

  assign report = finish && upd.started && upd.equals && key_ok;

  always_comb begin
    st_o   = upd;
    res_o  = '0;
    fire_o = 1'b0;
    if (st_i.in_payload) begin
      res_o.kind         = gckp_pkg::KIND_PAYLOAD;
      res_o.payload_byte = byte_i;
      fire_o             = 1'b1;
    end else if (report) begin
      res_o.kind             = gckp_pkg::KIND_PAIR;
      res_o.key_char         = upd.key;
      res_o.magnitude        = upd.value.acc;
      res_o.is_negative      = upd.value.minus;
      res_o.first_value_char = upd.value.first;
      res_o.value_empty      = (upd.value.len == 2'd0);
      res_o.value_is_one     = (upd.value.len == 2'd1) &&
                               (upd.value.first == gckp_pkg::ChOne);
      fire_o                 = 1'b1;
    end
    if (finish) begin
      st_o            = '0;
      st_o.in_payload = upd.in_payload;
    end
    if (last_i) begin
      if (!fire_o) begin
        res_o.kind = gckp_pkg::KIND_END;
      end
      res_o.last = 1'b1;
      fire_o     = 1'b1;
      st_o       = '0;
    end
  end

endmodule

FILE: src/graphics_command_kv_parser_top.sv
// ----------------------------------------------------------------------------
// graphics_command_kv_parser_top
// Byte-serial key=value parser for graphics control strings.
// ----------------------------------------------------------------------------
// Feed the control string one byte per request, with in_last_i on its final
// byte. Before the first ';' the parser splits comma-separated pairs and
// emits one kind_o = pair result for each completed pair whose key is a
// recognized letter and whose value follows an '=' that is not the first
// byte; bytes after the ';' come out one per result as payload. The final
// byte always yields a result with out_last_o set (an end marker if nothing
// else is due), and the parser then starts fresh. Throughput is one byte per
// clock while the result side does not stall: a byte waits in an input
// register, and the decode (pair tracking and a multiply-by-ten accumulate)
// writes the result register. A result shows on out_valid_o once its byte has
// passed the input register and then the result register. When both
// registers are full, in_ready_o follows out_ready_i combinationally, so
// a full pipe stalls as one unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module graphics_command_kv_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  key_char_o,
  output logic [31:0] magnitude_o,
  output logic        is_negative_o,
  output logic [7:0]  first_value_char_o,
  output logic        value_empty_o,
  output logic        value_is_one_o,
  output logic [7:0]  payload_byte_o,
  output logic        out_last_o
);

  // Input register
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;

  // Parse state and result register
  gckp_pkg::parse_t  st_q, st_d;
  gckp_pkg::result_t res_q, res_d;
  logic              out_vld_q;
  logic              fire;

  logic              advance;   // result register free this cycle
  logic              process;   // byte in the input register is decoded

  assign advance    = !out_vld_q || out_ready_i;
  assign process    = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  // Hold the accepted byte until the decode stage can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  gckp_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .st_o   (st_d),
    .fire_o (fire),
    .res_o  (res_d)
  );

  // Advance the parse state only on a decoded byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= process && fire;
      if (process) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign kind_o             = res_q.kind;
  assign key_char_o         = res_q.key_char;
  assign magnitude_o        = res_q.magnitude;
  assign is_negative_o      = res_q.is_negative;
  assign first_value_char_o = res_q.first_value_char;
  assign value_empty_o      = res_q.value_empty;
  assign value_is_one_o     = res_q.value_is_one;
  assign payload_byte_o     = res_q.payload_byte;
  assign out_last_o         = res_q.last;

  // Payload mode ends only after the final byte of a string is decoded
  `GCKP_ASSERT(a_payload_exit, clk_i, rst_ni, $fell(st_q.in_payload) |-> $past(process && in_last_q), "payload mode left without a final byte")
  // A stalled input register keeps its byte
  `GCKP_ASSERT(a_in_hold, clk_i, rst_ni, (in_vld_q && !advance) |=> in_vld_q, "input byte dropped while stalled")
  // Value length counter saturates at two
  `GCKP_NEVER(a_len_sat, clk_i, rst_ni, st_q.value.len == 2'd3, "value length counter overflow")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the graphics control string parser: streams
// directed and random control strings through the request channel, predicts
// every result from its own copy of the parse state, and compares each
// returned result field by field, in order, under random stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake on either side
  localparam int TAIL_CYCLES  = 8;      // drain slack for a stray result
  localparam int RANDOM_BYTES = 660;
  localparam int DRAIN_EVERY  = 150;

  // Key letters the parser reports; anything else is silently dropped.
  localparam logic [7:0] KEY_LETTERS [14] = '{
    "a", "f", "t", "i", "p", "s", "v", "c", "r", "z", "m", "C", "q", "d"
  };

  // --------------------------------------------------------------------------
  // DUT signals, inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = '0;
  logic        in_last_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  key_char_o;
  logic [31:0] magnitude_o;
  logic        is_negative_o;
  logic [7:0]  first_value_char_o;
  logic        value_empty_o;
  logic        value_is_one_o;
  logic [7:0]  payload_byte_o;
  logic        out_last_o;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  gckp_pkg::parse_t  model_st = '0;       // predicted parser state
  gckp_pkg::result_t pending_results[$];  // predicted results not yet returned
  logic [7:0]        cmd_bytes[$];        // control string being assembled
  bit                quiet = 1'b0;        // suppress idling on both sides
  int                stall_left = 0;
  int                error_count = 0;
  int                requests_sent = 0;
  int                commands_sent = 0;
  int                pairs_seen = 0;
  int                payload_seen = 0;
  int                ends_seen = 0;

  graphics_command_kv_parser_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_byte_i          (in_byte_i),
    .in_last_i          (in_last_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .key_char_o         (key_char_o),
    .magnitude_o        (magnitude_o),
    .is_negative_o      (is_negative_o),
    .first_value_char_o (first_value_char_o),
    .value_empty_o      (value_empty_o),
    .value_is_one_o     (value_is_one_o),
    .payload_byte_o     (payload_byte_o),
    .out_last_o         (out_last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Parser prediction
  // --------------------------------------------------------------------------

  // Close the current pair: report it if it has a known key and an '=' past
  // its first byte, then clear everything but the payload flag.
  function automatic bit close_pair(output gckp_pkg::result_t res);
    bit   known;
    bit   report;
    logic keep;
    known = 1'b0;
    res   = '0;
    for (int k = 0; k < 14; k++) begin
      if (KEY_LETTERS[k] == model_st.key) known = 1'b1;
    end
    report = model_st.started && model_st.equals && known;
    if (report) begin
      res.kind             = gckp_pkg::KIND_PAIR;
      res.key_char         = model_st.key;
      res.magnitude        = model_st.value.acc;
      res.is_negative      = model_st.value.minus;
      res.first_value_char = model_st.value.first;
      res.value_empty      = (model_st.value.len == 2'd0);
      res.value_is_one     = (model_st.value.len == 2'd1) &&
                             (model_st.value.first == gckp_pkg::ChOne);
    end
    keep                = model_st.in_payload;
    model_st            = '0;
    model_st.in_payload = keep;
    return report;
  endfunction

  // Advance the predicted state by one accepted byte; return 1 with the
  // expected result in res when the byte causes one.
  function automatic bit predict_result(input logic [7:0] b, input logic last,
                                        output gckp_pkg::result_t res);
    bit          has;
    logic [63:0] prod;
    has = 1'b0;
    res = '0;
    if (model_st.in_payload) begin
      res.kind         = gckp_pkg::KIND_PAYLOAD;
      res.payload_byte = b;
      has              = 1'b1;
    end else if (b == gckp_pkg::ChSemi) begin
      has                 = close_pair(res);
      model_st.in_payload = 1'b1;
    end else if (b == gckp_pkg::ChComma) begin
      has = close_pair(res);
    end else begin
      if (!model_st.started) begin
        model_st.key     = b;
        model_st.started = 1'b1;
      end else if (!model_st.equals) begin
        if (b == gckp_pkg::ChEquals) model_st.equals = 1'b1;
      end else begin
        // Value byte: track first byte and length, then run the atoi decode.
        if (model_st.value.len == 2'd0) model_st.value.first = b;
        if (model_st.value.len < 2'd2) model_st.value.len = model_st.value.len + 2'd1;
        if (model_st.value.phase != gckp_pkg::PH_DONE) begin
          if (b >= gckp_pkg::ChZero && b <= gckp_pkg::ChNine) begin
            prod = {32'd0, model_st.value.acc} * 64'd10 + {56'd0, b - gckp_pkg::ChZero};
            model_st.value.acc   = (prod > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                    : prod[31:0];
            model_st.value.phase = gckp_pkg::PH_NUM;
          end else if (model_st.value.phase == gckp_pkg::PH_SKIP &&
                       (b == gckp_pkg::ChSpace ||
                        (b >= gckp_pkg::ChTab && b <= gckp_pkg::ChCr))) begin
            // leading whitespace, keep skipping
          end else if (model_st.value.phase == gckp_pkg::PH_SKIP &&
                       (b == gckp_pkg::ChPlus || b == gckp_pkg::ChMinus)) begin
            model_st.value.minus = (b == gckp_pkg::ChMinus);
            model_st.value.phase = gckp_pkg::PH_NUM;
          end else begin
            model_st.value.phase = gckp_pkg::PH_DONE;
          end
        end
      end
      if (last) has = close_pair(res);
    end
    if (last) begin
      if (!has) begin
        res      = '0;
        res.kind = gckp_pkg::KIND_END;
        has      = 1'b1;
      end
      res.last = 1'b1;
      model_st = '0;
    end
    return has;
  endfunction

  // --------------------------------------------------------------------------
  // Idling and handshakes
  // --------------------------------------------------------------------------

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive the result side at the falling edge: hold ready low for a random
  // stall, then raise it and maybe schedule the next stall.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left  = stall_left - 1;
    end else begin
      out_ready_i = 1'b1;
      stall_left  = ($urandom_range(0, 99) < 35) ? pick_gap() : 0;
    end
  end

  // Send one request. Called at a falling edge and returns at one; valid
  // stays high into the next request when no gap follows.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int                gap;
    gckp_pkg::result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i  = b;
    in_last_i  = last;
    do @(posedge clk_i); while (!in_ready_o);
    // Accepted at this edge: predict before the result can come back.
    if (predict_result(b, last, res)) pending_results.push_back(res);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Send the assembled control string with last on its final byte.
  task automatic send_command();
    for (int i = 0; i < cmd_bytes.size(); i++) begin
      send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
    end
    cmd_bytes.delete();
    commands_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Sample at the rising edge; every accepted result must match the oldest
  // prediction.
  always @(posedge clk_i) begin
    gckp_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind 0x%0h last %0b", kind_o, out_last_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind",             want.kind,             kind_o);
        check_field("key_char",         want.key_char,         key_char_o);
        check_field("magnitude",        want.magnitude,        magnitude_o);
        check_field("is_negative",      want.is_negative,      is_negative_o);
        check_field("first_value_char", want.first_value_char, first_value_char_o);
        check_field("value_empty",      want.value_empty,      value_empty_o);
        check_field("value_is_one",     want.value_is_one,     value_is_one_o);
        check_field("payload_byte",     want.payload_byte,     payload_byte_o);
        check_field("out_last",         want.last,             out_last_o);
        case (want.kind)
          gckp_pkg::KIND_PAIR:    pairs_seen++;
          gckp_pkg::KIND_PAYLOAD: payload_seen++;
          default:                ends_seen++;
        endcase
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("no handshake for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Assemble one random control string. Most are well formed with random
  // content; some carry broken pairs or are plain noise.
  task automatic build_random_command();
    int         r;
    int         npairs;
    int         nbytes;
    logic [7:0] key;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      nbytes = $urandom_range(1, 10);
      repeat (nbytes) cmd_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      npairs = $urandom_range(0, 4);
      for (int j = 0; j < npairs; j++) begin
        if (j > 0) cmd_bytes.push_back(gckp_pkg::ChComma);
        r   = $urandom_range(0, 99);
        key = (r < 85) ? KEY_LETTERS[$urandom_range(0, 13)] : 8'($urandom_range(0, 255));
        r   = $urandom_range(0, 99);
        if (r < 5) begin
          // pair opening with '='
          key = gckp_pkg::ChEquals;
        end
        cmd_bytes.push_back(key);
        if (r >= 5 && r < 12) begin
          // broken pair: no equals sign at all
          push_text("x9");
          continue;
        end
        cmd_bytes.push_back(gckp_pkg::ChEquals);
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // empty value
        end else if (r < 25) begin
          cmd_bytes.push_back(gckp_pkg::ChOne);
        end else if (r < 35) begin
          cmd_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
          if ($urandom_range(0, 1)) cmd_bytes.push_back(gckp_pkg::ChOne);
        end else begin
          repeat ($urandom_range(0, 2)) begin
            cmd_bytes.push_back(($urandom_range(0, 3) == 0) ? gckp_pkg::ChSpace
                                                            : 8'($urandom_range(9, 13)));
          end
          case ($urandom_range(0, 2))
            0: ;
            1: cmd_bytes.push_back(gckp_pkg::ChPlus);
            default: cmd_bytes.push_back(gckp_pkg::ChMinus);
          endcase
          // Mostly short numbers; now and then enough digits to saturate.
          nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
          repeat (nbytes) cmd_bytes.push_back(8'(gckp_pkg::ChZero + $urandom_range(0, 9)));
          if ($urandom_range(0, 99) < 20) begin
            cmd_bytes.push_back(8'($urandom_range(0, 255)));
            cmd_bytes.push_back(8'(gckp_pkg::ChZero + $urandom_range(0, 9)));
          end
        end
      end
      if ($urandom_range(0, 99) < 45) begin
        cmd_bytes.push_back(gckp_pkg::ChSemi);
        nbytes = $urandom_range(0, 6);
        repeat (nbytes) cmd_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (cmd_bytes.size() == 0) cmd_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Sign without digits, '=' as first byte, no '=', unknown key, empty value
  // on the final byte, and a lone final byte with nothing to report.
  task automatic test_pair_rules();
    push_text("a=-,=q,m,b=7,z=");
    send_command();
    push_text("x");
    send_command();
  endtask

  // Leading tab, minus sign, digits stopping at a non-digit, and a value of
  // exactly "1" closed by the final byte.
  task automatic test_number_decode();
    push_text("q=");
    cmd_bytes.push_back(gckp_pkg::ChTab);
    push_text("-1x2,s=1");
    send_command();
  endtask

  // Payload extremes including a ';' inside the payload, then a ';' that is
  // itself the final byte and closes a pair. Drain before moving on.
  task automatic test_payload();
    push_text("p;");
    cmd_bytes.push_back(8'h00);
    cmd_bytes.push_back(8'hFF);
    cmd_bytes.push_back(gckp_pkg::ChSemi);
    send_command();
    push_text("f=1;");
    send_command();
    wait_drained();
  endtask

  // Bulk random strings; pause now and then until the pipe is empty.
  task automatic test_random_commands();
    int next_drain;
    next_drain = requests_sent + DRAIN_EVERY;
    while (requests_sent < RANDOM_BYTES) begin
      build_random_command();
      send_command();
      if (requests_sent >= next_drain) begin
        wait_drained();
        next_drain = requests_sent + DRAIN_EVERY;
      end
    end
  endtask

  // Full rate on both sides: no request gaps and no result stalls.
  task automatic test_back_to_back();
    quiet      = 1'b1;
    stall_left = 0;
    repeat (6) begin
      build_random_command();
      send_command();
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Assert reset once, release it on a falling edge.
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_pair_rules();
    test_number_decode();
    test_payload();
    test_back_to_back();
    test_random_commands();
    test_back_to_back();

    // Drain, then allow the pipe latency for any stray result to surface.
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never returned", pending_results.size());
      error_count += pending_results.size();
    end

    $display("Sent %0d requests in %0d control strings under random stalls.",
             requests_sent, commands_sent);
    $display("Checked %0d pair, %0d payload and %0d end-marker results.",
             pairs_seen, payload_seen, ends_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
